@@ rtl/lkvc_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CAP_W      = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode               opcode;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] write_value;
    } t_in_word;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
    } t_out_word;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic shift;
        logic in_range;
    } t_cell_ctrl;

endpackage

@@ rtl/lkvc_cell.sv @@
// One recency-ordered storage cell of the LRU cache chain.
module lkvc_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lkvc_pkg::t_cell_ctrl               i_ctrl,
    input  lkvc_pkg::t_entry                   i_prev,
    input  logic [lkvc_pkg::KEY_BITS-1:0]      i_key,
    output lkvc_pkg::t_entry                   o_entry,
    output logic                               o_match
);

    logic                              r_valid;
    logic [lkvc_pkg::KEY_BITS-1:0]     r_key;
    logic [lkvc_pkg::VALUE_BITS-1:0]   r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            // An entry pushed past the capacity limit falls out of the cache.
            r_valid <= i_prev.valid & i_ctrl.in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_entry.value = r_value;
    assign o_match       = r_valid && (r_key == i_key);

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Top level of the LRU key/value cache: a recency-ordered chain of cells.
//
// Usage: a request word (get or put, key, value) enters on i_in_valid/o_in_ready
// and one response word (hit, read value, eviction flag and key) leaves on
// o_out_valid/i_out_ready. Each accepted word is looked up against all cells at
// once and the chain is updated at the same clock edge; the response appears in
// the output register on the next cycle, so latency is one cycle and a new
// word may be taken every cycle. The figure is set by the single-cycle key
// compare and one-step shift along the cell chain.
// Cell 0 holds the most recent entry; a hit or insert moves the entry to cell 0
// and every more recent cell moves one place down. When full, the entry in
// the last cell within the capacity is evicted.
// If the receiver stalls, the response stays in the output register and one
// further word is taken only in the cycle the held response is collected.
// Reset (synchronous, active low) empties the cache and sets the capacity to
// 16. Writing the capacity register (i_cfg_we) also empties the cache; it is to
// be written only while no word is in flight.
module lru_key_value_cache (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lkvc_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lkvc_pkg::t_out_word             o_out_word
);

    localparam int N = lkvc_pkg::ENTRIES;

    logic [lkvc_pkg::CAP_W-1:0]        r_cap;
    logic [lkvc_pkg::CAP_W-1:0]        w_cap_eff;
    logic                              r_out_valid;
    lkvc_pkg::t_out_word               r_out_word;
    lkvc_pkg::t_out_word               n_out_word;

    lkvc_pkg::t_entry                  w_entry [N];
    lkvc_pkg::t_cell_ctrl              w_ctrl  [N];
    logic [N-1:0]                      w_match;
    logic [N-1:0]                      w_valid;
    logic [N-1:0]                      w_last;
    lkvc_pkg::t_entry                  w_front;
    logic                              w_accept;
    logic                              w_found;
    logic                              w_is_put;
    logic                              w_evict;
    logic [lkvc_pkg::VALUE_BITS-1:0]   w_hit_value;
    logic [lkvc_pkg::KEY_BITS-1:0]     w_last_key;

    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_put   = (i_in_word.opcode == lkvc_pkg::OP_PUT);
    assign w_found    = |w_match;

    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = lkvc_pkg::CAP_W'(1);
        end else if (r_cap > lkvc_pkg::CAP_W'(N)) begin
            w_cap_eff = lkvc_pkg::CAP_W'(N);
        end else begin
            w_cap_eff = r_cap;
        end
    end

    always_comb begin
        w_hit_value = '0;
        w_last_key  = '0;
        for (int i = 0; i < N; i++) begin
            if (w_match[i]) begin
                w_hit_value = w_hit_value | w_entry[i].value;
            end
            if (w_last[i]) begin
                w_last_key = w_last_key | w_entry[i].key;
            end
        end
    end

    // The cache is full exactly when the last cell within the capacity holds an entry.
    assign w_evict = w_is_put && !w_found && |(w_last & w_valid);

    assign w_front.valid = 1'b1;
    assign w_front.key   = i_in_word.lookup_key;
    assign w_front.value = w_is_put ? i_in_word.write_value : w_hit_value;

    for (genvar g = 0; g < N; g++) begin : g_cell
        lkvc_pkg::t_entry w_prev;

        if (g == 0) begin : g_head
            assign w_prev = w_front;
        end else begin : g_body
            assign w_prev = w_entry[g-1];
        end

        assign w_valid[g]           = w_entry[g].valid;
        assign w_last[g]            = (lkvc_pkg::CAP_W'(g + 1) == w_cap_eff);
        assign w_ctrl[g].clear      = i_cfg_we;
        assign w_ctrl[g].in_range   = (lkvc_pkg::CAP_W'(g) < w_cap_eff);
        // On a hit only the cells up to the hit position move; a put that misses
        // moves the whole chain.
        assign w_ctrl[g].shift      = w_accept &&
                                      (w_found ? ((w_match >> g) != '0) : w_is_put);

        lkvc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[g]),
            .i_prev  (w_prev),
            .i_key   (i_in_word.lookup_key),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    always_comb begin
        n_out_word.hit         = w_found;
        n_out_word.read_value  = (w_found && !w_is_put) ? w_hit_value : '0;
        n_out_word.evicted     = w_evict;
        n_out_word.evicted_key = w_evict ? w_last_key : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Keys in the chain are unique.
    a_unique_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matches the key");

    // Occupied cells always form an unbroken run from cell 0.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & (w_valid + 1'b1)) == '0))
        else $error("occupied cells are not contiguous");

    // Occupancy never exceeds the capacity in use.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_valid) <= int'(w_cap_eff)))
        else $error("occupancy exceeds capacity");

    // A put without a simultaneous capacity write leaves its key in the most recent cell.
    a_put_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_put && !i_cfg_we) |=>
            (w_entry[0].valid && (w_entry[0].key == $past(i_in_word.lookup_key))))
        else $error("put key not at the front of the chain");

endmodule
